// File: rtl/core/fpsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpsa_pkg;

  localparam int unsigned MaxPages = 32768;
  localparam int unsigned PageBits = 12;
  localparam int unsigned AddrBits = 56;
  localparam int unsigned PageNumW = AddrBits - PageBits;
  localparam int unsigned PtrW     = $clog2(MaxPages);
  localparam int unsigned CountW   = $clog2(MaxPages + 1);
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [AddrBits-1:0] LowBoundReset  = AddrBits'(64'h8000_0000);
  localparam logic [AddrBits-1:0] HighBoundReset = AddrBits'(64'h8800_0000);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_FREE  = 2'd1,
    OP_ALLOC = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW  = 1'd0,
    CFG_HIGH = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_INIT
  } state_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [AddrBits-1:0] page_address;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [AddrBits-1:0] allocated_address;
    logic [CountW-1:0]   free_count;
  } rsp_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [PtrW-1:0]     addr;
    logic [PageNumW-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/core/free_page_stack_allocator_top.sv
// Channel   Signals                              Handshake
// command   start, busy, req_i                   taken when start && !busy
// result    done_o, rsp_o                        valid for the one cycle done_o is high
// config    cfg_we_i, cfg_index_i, cfg_data_i    written when cfg_we_i is high
//
// Free and unused codes: result in the cycle after the item is taken; busy stays low.
// Alloc: one stack memory read via S_POP (none if empty); busy stays high in S_POP.
// Init: one push per cycle through the single memory write port, result after the
// last push or when full; busy stays high meanwhile.
// Reset clears count, state and done, sets default bounds; memory needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module free_page_stack_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  fpsa_pkg::req_t                 req_i,
  output logic                           done_o,
  output fpsa_pkg::rsp_t                 rsp_o,
  input  logic                           cfg_we_i,
  input  logic [fpsa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fpsa_pkg::AddrBits-1:0]  cfg_data_i
);
  import fpsa_pkg::*;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [PageNumW:0]   next_q, next_d;
  logic [PageNumW-1:0] limit_q, limit_d;
  logic [AddrBits-1:0] low_q, high_q;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;
  mem_req_t            mem_req;
  logic [PageNumW-1:0] rdata;
  logic                accept;
  logic                free_bad;
  logic                full;

  assign accept   = start && (state_q == S_IDLE);
  assign full     = (count_q == CountW'(MaxPages));
  assign free_bad = (|req_i.page_address[PageBits-1:0])
                    || (req_i.page_address < low_q)
                    || (req_i.page_address >= high_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(req_i.operation))
            OP_INIT:  state_d = S_INIT;
            OP_ALLOC: state_d = (count_q != '0) ? S_POP : S_IDLE;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_POP:   state_d = S_IDLE;
      S_INIT: begin
        if ((next_q >= {1'b0, limit_q}) || full) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    next_d  = next_q;
    limit_d = limit_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    mem_req = '{we: 1'b0, re: 1'b0, addr: count_q[PtrW-1:0], wdata: '0};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(req_i.operation))
            OP_INIT: begin
              count_d = '0;
              next_d  = {1'b0, low_q[AddrBits-1:PageBits]}
                        + (PageNumW+1)'(|low_q[PageBits-1:0]);
              limit_d = high_q[AddrBits-1:PageBits];
            end
            OP_FREE: begin
              done_d = 1'b1;
              if (free_bad) begin
                rsp_d = '{status: ST_BAD, allocated_address: '0, free_count: count_q};
              end else if (full) begin
                rsp_d = '{status: ST_FULL, allocated_address: '0, free_count: count_q};
              end else begin
                mem_req.we    = 1'b1;
                mem_req.wdata = req_i.page_address[AddrBits-1:PageBits];
                count_d       = count_q + 1'b1;
                rsp_d = '{status: ST_OK, allocated_address: '0, free_count: count_d};
              end
            end
            OP_ALLOC: begin
              if (count_q == '0) begin
                done_d = 1'b1;
                rsp_d  = '{status: ST_EMPTY, allocated_address: '0, free_count: count_q};
              end else begin
                count_d      = count_q - 1'b1;
                mem_req.re   = 1'b1;
                mem_req.addr = count_d[PtrW-1:0];
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '{status: ST_OK, allocated_address: '0, free_count: count_q};
            end
          endcase
        end
      end
      S_POP: begin
        done_d = 1'b1;
        rsp_d  = '{status: ST_OK, allocated_address: {rdata, PageBits'(0)},
                   free_count: count_q};
      end
      S_INIT: begin
        if (next_q >= {1'b0, limit_q}) begin
          done_d = 1'b1;
          rsp_d  = '{status: ST_OK, allocated_address: '0, free_count: count_q};
        end else if (full) begin
          done_d = 1'b1;
          rsp_d  = '{status: ST_FULL, allocated_address: '0, free_count: count_q};
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = next_q[PageNumW-1:0];
          count_d       = count_q + 1'b1;
          next_d        = next_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      low_q   <= LowBoundReset;
      high_q  <= HighBoundReset;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LOW:  low_q  <= cfg_data_i;
          CFG_HIGH: high_q <= cfg_data_i;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    next_q  <= next_d;
    limit_q <= limit_d;
    rsp_q   <= rsp_d;
  end

  fpsa_stack_mem u_stack_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// File: rtl/core/fpsa_stack_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module fpsa_stack_mem (
  input  logic                          clk_i,
  input  fpsa_pkg::mem_req_t            mem_req_i,
  output logic [fpsa_pkg::PageNumW-1:0] rdata_o
);
  import fpsa_pkg::*;

  logic [PageNumW-1:0] mem_q [MaxPages];
  logic [PageNumW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.addr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/fpsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fpsa_sva (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input fpsa_pkg::req_t req_i,
  input logic           done_o,
  input fpsa_pkg::rsp_t rsp_o
);
  import fpsa_pkg::*;

  a_free_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.operation == OP_FREE) |=> (done_o && !busy))
    else $error("free item gave no result on the next cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> (rsp_o.free_count == '0))
    else $error("empty status with pages held");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (rsp_o.free_count == CountW'(MaxPages)))
    else $error("full status below capacity");

  a_addr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((rsp_o.allocated_address[PageBits-1:0] == '0)
                && (rsp_o.allocated_address == '0 || rsp_o.status == ST_OK)))
    else $error("bad allocated address");

endmodule

bind free_page_stack_allocator_top fpsa_sva u_fpsa_sva (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
